// ===== src/sharp12_remote_segment_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the remote segment encoder
// Immediate-consequence and next-cycle checks, clocked on aclk and held off
// while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SHARP12_REMOTE_SEGMENT_ENCODER_ASSERT_SVH
`define SHARP12_REMOTE_SEGMENT_ENCODER_ASSERT_SVH

// cond holds in the same cycle as trig
`define S12RSE_ASSERT_IMP(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (cond)) else $error(msg);

// cond holds in the cycle after trig
`define S12RSE_ASSERT_NXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ===== src/s12rse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s12rse_pkg
// Shared types and constants of the remote segment encoder.
// ----------------------------------------------------------------------------
package s12rse_pkg;

    localparam int DATA_BITS_DEF = 12;
    localparam int CODE_W        = 8;
    localparam int DUR_W         = 16;
    localparam int CODE_SHIFT    = 3;
    localparam int Q_DEPTH       = 2;

    // APB register map, word index = paddr[4:2]
    localparam int PADDR_W = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_HIGH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAP_ONE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAP_ZERO     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_TRAILER  = 3'd4;

    localparam logic [DUR_W-1:0] RST_PULSE_HIGH   = 16'd320;
    localparam logic [DUR_W-1:0] RST_GAP_ONE      = 16'd1680;
    localparam logic [DUR_W-1:0] RST_GAP_ZERO     = 16'd680;
    localparam logic [DUR_W-1:0] RST_FRAME_PERIOD = 16'd50000;
    localparam logic [DUR_W-1:0] RST_MIN_TRAILER  = 16'd1000;

    typedef struct packed {
        logic [DUR_W-1:0] pulse_high;
        logic [DUR_W-1:0] gap_one;
        logic [DUR_W-1:0] gap_zero;
        logic [DUR_W-1:0] frame_period;
        logic [DUR_W-1:0] min_trailer;
    } cfg_t;

    // queue status seen by the back end
    typedef struct packed {
        logic valid;
    } q_stat_t;

endpackage

// ===== src/sharp12_remote_segment_encoder.sv =====
`timescale 1ns / 1ps
// A code passes the queue, the sequencer registers and then the output register.
// Throughput: one segment per cycle unless stalled, 2*(2*DATA_BITS+2) = 52 per code,
// set by the single segment sequencer in the back end; codes run back to back.
// A two-entry queue takes new codes while the sequencer is busy.
// Reset: synchronous active-low aresetn empties queue and output, and
// loads the timing registers with 320/1680/680/50000/1000 us.
// ----------------------------------------------------------------------------
// sharp12_remote_segment_encoder
// Pulse-distance remote encoder: command code in, (level, duration) out.
// ----------------------------------------------------------------------------
module sharp12_remote_segment_encoder #(
    parameter int DATA_BITS = s12rse_pkg::DATA_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] code
    // segment output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [0] level, [16:1] duration_us
    output logic                                m_tuser,   // [0] inverted_frame
    output logic                                m_tlast,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [s12rse_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

`include "sharp12_remote_segment_encoder_assert.svh"

    // ------------------------------------------------------------------
    // Timing registers. Writes land in the access phase; unused word
    // addresses are ignored and read back as zero.
    // ------------------------------------------------------------------
    s12rse_pkg::cfg_t                    cfg_reg, cfg_next;
    logic                                wr_en;
    logic [s12rse_pkg::REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[s12rse_pkg::PADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                s12rse_pkg::REG_PULSE_HIGH:   cfg_next.pulse_high   = pwdata[15:0];
                s12rse_pkg::REG_GAP_ONE:      cfg_next.gap_one      = pwdata[15:0];
                s12rse_pkg::REG_GAP_ZERO:     cfg_next.gap_zero     = pwdata[15:0];
                s12rse_pkg::REG_FRAME_PERIOD: cfg_next.frame_period = pwdata[15:0];
                s12rse_pkg::REG_MIN_TRAILER:  cfg_next.min_trailer  = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            s12rse_pkg::REG_PULSE_HIGH:   prdata = {16'd0, cfg_reg.pulse_high};
            s12rse_pkg::REG_GAP_ONE:      prdata = {16'd0, cfg_reg.gap_one};
            s12rse_pkg::REG_GAP_ZERO:     prdata = {16'd0, cfg_reg.gap_zero};
            s12rse_pkg::REG_FRAME_PERIOD: prdata = {16'd0, cfg_reg.frame_period};
            s12rse_pkg::REG_MIN_TRAILER:  prdata = {16'd0, cfg_reg.min_trailer};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_high   <= s12rse_pkg::RST_PULSE_HIGH;
            cfg_reg.gap_one      <= s12rse_pkg::RST_GAP_ONE;
            cfg_reg.gap_zero     <= s12rse_pkg::RST_GAP_ZERO;
            cfg_reg.frame_period <= s12rse_pkg::RST_FRAME_PERIOD;
            cfg_reg.min_trailer  <= s12rse_pkg::RST_MIN_TRAILER;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: code capture and frame-word queue
    // ------------------------------------------------------------------
    s12rse_pkg::q_stat_t   q_stat;
    logic [DATA_BITS-1:0]  q_word;
    logic                  q_pop;

    s12rse_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_pop    (q_pop),
        .q_stat   (q_stat),
        .q_word   (q_word)
    );

    // ------------------------------------------------------------------
    // Back end: segment sequencer with registered output
    // ------------------------------------------------------------------
    s12rse_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // the closing segment of a code is the low pad of the inverted frame
    `S12RSE_ASSERT_IMP(a_last_is_inv_pad, m_tvalid && m_tlast, m_tuser && !m_tdata[0], "last segment is not the inverted-frame pad")
    // backpressure on the input only when the queue holds a word
    `S12RSE_ASSERT_IMP(a_stall_has_word, !s_tready, q_stat.valid, "input stalled with empty queue")
    // a pop always leaves room for the next code
    `S12RSE_ASSERT_NXT(a_pop_frees_slot, q_pop && !(s_tvalid && s_tready), s_tready, "queue full after pop")

endmodule

// ===== src/s12rse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s12rse_front
// Accepts command codes, forms the frame word and queues it for the back end.
// ----------------------------------------------------------------------------
module s12rse_front #(
    parameter int DATA_BITS = s12rse_pkg::DATA_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [s12rse_pkg::CODE_W-1:0]     s_tdata,
    input  logic                              q_pop,
    output s12rse_pkg::q_stat_t               q_stat,
    output logic [DATA_BITS-1:0]              q_word
);

    localparam int QD    = s12rse_pkg::Q_DEPTH;
    localparam int QA_W  = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC_W  = $clog2(QD + 1);

    logic [DATA_BITS-1:0] mem_reg [QD];
    logic [QA_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]      cnt_reg, cnt_next;
    logic [31:0]          shifted;
    logic [DATA_BITS-1:0] word;
    logic                 push;
    logic                 pop;

    // code shifted into the frame word; bits above DATA_BITS fall away
    assign shifted = 32'(s_tdata) << s12rse_pkg::CODE_SHIFT;
    assign word    = shifted[DATA_BITS-1:0];

    assign s_tready     = (cnt_reg != QC_W'(QD));
    assign push         = s_tvalid && s_tready;
    assign pop          = q_pop && (cnt_reg != '0);
    assign q_stat.valid = (cnt_reg != '0);
    assign q_word       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= word;
        end
    end

endmodule

// ===== src/s12rse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s12rse_back
// Segment sequencer: walks both frames of a word, one segment per cycle unless
// the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module s12rse_back #(
    parameter int DATA_BITS = s12rse_pkg::DATA_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  s12rse_pkg::cfg_t                  cfg,
    input  s12rse_pkg::q_stat_t               q_stat,
    input  logic [DATA_BITS-1:0]              q_word,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int DW    = s12rse_pkg::DUR_W;
    localparam int SEGS  = 2 * DATA_BITS + 2;
    localparam int POS_W = $clog2(SEGS);
    localparam int ACC_W = DW + $clog2(SEGS);
    localparam logic [POS_W-1:0] POS_PAD     = POS_W'(2 * DATA_BITS + 1);

    logic                 active_reg, active_next;
    logic                 frame_reg, frame_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [DATA_BITS-1:0] word_reg, word_next;
    logic [DATA_BITS-1:0] sh_reg, sh_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;

    logic                 ov_reg, ov_next;
    logic                 olevel_reg;
    logic [DW-1:0]        odur_reg;
    logic                 oinv_reg;
    logic                 olast_reg;

    logic                 is_pad;
    logic                 level;
    logic [DW-1:0]        pad_dur;
    logic [DW-1:0]        diff;
    logic [DW-1:0]        dur;
    logic                 fin;
    logic                 fire;

    assign is_pad = (pos_reg == POS_PAD);
    assign level  = !pos_reg[0];
    assign fin    = frame_reg && is_pad;
    assign fire   = active_reg && (!ov_reg || m_tready);
    assign q_pop  = q_stat.valid && (!active_reg || (fire && fin));

    // pad fills the frame to its period, never below the minimum gap
    assign diff = cfg.frame_period - acc_reg[DW-1:0];
    always_comb begin
        if (acc_reg > ACC_W'(cfg.frame_period)) begin
            pad_dur = cfg.min_trailer;
        end else if (diff < cfg.min_trailer) begin
            pad_dur = cfg.min_trailer;
        end else begin
            pad_dur = diff;
        end
    end

    always_comb begin
        if (level) begin
            dur = cfg.pulse_high;
        end else if (is_pad) begin
            dur = pad_dur;
        end else begin
            dur = sh_reg[0] ? cfg.gap_one : cfg.gap_zero;
        end
    end

    always_comb begin
        active_next = active_reg;
        frame_next  = frame_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        sh_next     = sh_reg;
        acc_next    = acc_reg;
        if (fire) begin
            acc_next = acc_reg + ACC_W'(dur);
            pos_next = pos_reg + 1'b1;
            if (!level && !is_pad) begin
                sh_next = sh_reg >> 1;
            end
            if (is_pad) begin
                pos_next   = '0;
                acc_next   = '0;
                frame_next = 1'b1;
                sh_next    = ~word_reg;
                if (frame_reg) begin
                    active_next = 1'b0;
                end
            end
        end
        if (q_pop) begin
            active_next = 1'b1;
            frame_next  = 1'b0;
            pos_next    = '0;
            acc_next    = '0;
            word_next   = q_word;
            sh_next     = q_word;
        end
    end

    always_comb begin
        ov_next = ov_reg;
        if (fire) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        pos_reg   <= pos_next;
        word_reg  <= word_next;
        sh_reg    <= sh_next;
        acc_reg   <= acc_next;
        if (fire) begin
            olevel_reg <= level;
            odur_reg   <= dur;
            oinv_reg   <= frame_reg;
            olast_reg  <= fin;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, odur_reg, olevel_reg};
    assign m_tuser  = oinv_reg;
    assign m_tlast  = olast_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote segment encoder testbench
// Sends command codes through the input stream and checks every emitted
// (level, duration) segment against a segment list computed in the bench
// from its own copy of the timing registers. Timing is reprogrammed over APB
// between phases: reset values, all-zero, all-ones, short and exact pads,
// writes to unused addresses, then random settings with random codes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DATA_BITS    = s12rse_pkg::DATA_BITS_DEF;
    localparam int DUR_W        = s12rse_pkg::DUR_W;
    localparam int PADDR_W      = s12rse_pkg::PADDR_W;
    localparam int IDLE_PCT     = 15;       // chance of an idle cycle, per side
    localparam int QUIET_LO     = 9000;     // cycle window with no idling at all
    localparam int QUIET_HI     = 15000;
    localparam int HOLD_AT      = 5000;     // segment count that starts the long stall
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 8;        // settle time after the last segment
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 6;
    localparam int RAND_CODES   = 77;
    localparam int MAX_REPORTS  = 10;

    // one expected output segment
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
        logic             inv;
        logic             last;
    } segment_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;     // [7:0] code
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;           // [0] level, [16:1] duration_us
    logic                m_tuser;           // [0] inverted_frame
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // bench copy of the timing registers
    s12rse_pkg::cfg_t timing = '{pulse_high: s12rse_pkg::RST_PULSE_HIGH,
                                 gap_one: s12rse_pkg::RST_GAP_ONE,
                                 gap_zero: s12rse_pkg::RST_GAP_ZERO,
                                 frame_period: s12rse_pkg::RST_FRAME_PERIOD,
                                 min_trailer: s12rse_pkg::RST_MIN_TRAILER};

    logic [7:0] codes_waiting [$];          // codes not yet offered
    segment_t   segments_due [$];           // segments predicted, not yet seen

    int  cyc        = 0;
    int  seg_total  = 0;
    int  codes_sent = 0;
    int  settings   = 0;
    int  mismatches = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    wire quiet      = (cyc >= QUIET_LO) && (cyc < QUIET_HI);

    sharp12_remote_segment_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // Cycle count and run limit.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments still due",
                     cyc, segments_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // One frame: DATA_BITS pulse/gap pairs LSB first, trailer pulse, pad.
    // The pad never drops below the minimum gap, even when the bits alone
    // already overrun the frame period; the pad of the inverted frame closes
    // the code.
    function automatic void add_frame(input logic [DATA_BITS-1:0] word, input logic inv);
        longint       frame_len;
        longint       pad;
        logic [DUR_W-1:0] gap;
        frame_len = 0;
        for (int i = 0; i < DATA_BITS; i++) begin
            gap = word[i] ? timing.gap_one : timing.gap_zero;
            segments_due.push_back('{1'b1, timing.pulse_high, inv, 1'b0});
            segments_due.push_back('{1'b0, gap, inv, 1'b0});
            frame_len += longint'(timing.pulse_high) + longint'(gap);
        end
        segments_due.push_back('{1'b1, timing.pulse_high, inv, 1'b0});
        frame_len += longint'(timing.pulse_high);
        pad = longint'(timing.frame_period) - frame_len;
        if (pad < longint'(timing.min_trailer))
            pad = longint'(timing.min_trailer);
        segments_due.push_back('{1'b0, pad[DUR_W-1:0], inv, inv});
    endfunction

    // Code to segment list: frame word is code << 3 within DATA_BITS, any
    // bits pushed above the top are lost; the second frame is its inverse.
    function automatic void predict_segments(input logic [7:0] code);
        logic [31:0]          wide;
        logic [DATA_BITS-1:0] word;
        wide = {24'd0, code} << s12rse_pkg::CODE_SHIFT;
        word = wide[DATA_BITS-1:0];
        add_frame(word, 1'b0);
        add_frame(~word, 1'b1);
    endfunction

    // Sender: holds a code until taken, idles at random between codes.
    // Prediction happens on the edge where the request is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_segments(s_tdata);
                codes_sent <= codes_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (codes_waiting.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tdata  <= codes_waiting.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus one long stall once enough
    // segments have passed so the input queue fills and s_tready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && seg_total >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: every accepted segment against the oldest prediction.
    always @(posedge aclk) begin
        segment_t want;
        segment_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[DUR_W:1], m_tuser, m_tlast};
            seg_total <= seg_total + 1;
            if (segments_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected segment: level %0d dur %0d inv %0d last %0d",
                             got.level, got.dur, got.inv, got.last);
            end else begin
                want = segments_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("segment %0d: expected level %0d dur %0d inv %0d last %0d",
                                 seg_total, want.level, want.dur, want.inv, want.last);
                        $display("segment %0d: got      level %0d dur %0d inv %0d last %0d",
                                 seg_total, got.level, got.dur, got.inv, got.last);
                    end
                end
            end
        end
    end

    // Wait until all codes went in and all segments came out.
    // Polled on the falling edge to stay clear of the clocked processes.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (codes_waiting.size() != 0 || s_tvalid || segments_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup, access, release. Upper data bits are junk on purpose.
    task automatic write_reg(input int idx, input logic [DUR_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= {16'($urandom_range(16'hFFFF)), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            s12rse_pkg::REG_PULSE_HIGH:   timing.pulse_high   = val;
            s12rse_pkg::REG_GAP_ONE:      timing.gap_one      = val;
            s12rse_pkg::REG_GAP_ZERO:     timing.gap_zero     = val;
            s12rse_pkg::REG_FRAME_PERIOD: timing.frame_period = val;
            s12rse_pkg::REG_MIN_TRAILER:  timing.min_trailer  = val;
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [DUR_W-1:0] pulse, input logic [DUR_W-1:0] one,
                               input logic [DUR_W-1:0] zero, input logic [DUR_W-1:0] period,
                               input logic [DUR_W-1:0] min_gap);
        write_reg(s12rse_pkg::REG_PULSE_HIGH, pulse);
        write_reg(s12rse_pkg::REG_GAP_ONE, one);
        write_reg(s12rse_pkg::REG_GAP_ZERO, zero);
        write_reg(s12rse_pkg::REG_FRAME_PERIOD, period);
        write_reg(s12rse_pkg::REG_MIN_TRAILER, min_gap);
        settings++;
    endtask

    // Random register value: mostly realistic, sometimes an extreme.
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return DUR_W'($urandom_range(16'hFFFF));
            default: return DUR_W'($urandom_range(3000));
        endcase
    endfunction

    initial begin
        logic [7:0] reset_codes [8];
        reset_codes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset timing: normal pads above the minimum gap.
        settings++;
        foreach (reset_codes[i]) codes_waiting.push_back(reset_codes[i]);
        wait_drained();

        // Zero durations: all segments still emitted with length zero.
        load_timing('0, '0, '0, '0, '0);
        codes_waiting.push_back(8'h00);
        codes_waiting.push_back(8'hFF);
        codes_waiting.push_back(8'h3C);
        wait_drained();

        // All ones: frame overruns the period, pad clamps to the minimum gap.
        load_timing('1, '1, '1, '1, '1);
        codes_waiting.push_back(8'h00);
        codes_waiting.push_back(8'hFF);
        wait_drained();

        // Short period: bits alone exceed it, negative pad clamps.
        load_timing(16'd100, 16'd300, 16'd200, 16'd3000, 16'd500);
        codes_waiting.push_back(8'h00);
        codes_waiting.push_back(8'hFF);
        wait_drained();

        // Code 0: first frame is 250 us long, pad lands exactly on the
        // minimum; the inverted frame overruns and clamps.
        load_timing(16'd10, 16'd20, 16'd10, 16'd350, 16'd100);
        codes_waiting.push_back(8'h00);
        codes_waiting.push_back(8'hFF);
        wait_drained();

        // Writes to unused addresses must not disturb the timing.
        for (int r = int'(s12rse_pkg::REG_MIN_TRAILER) + 1;
             r < (1 << s12rse_pkg::REG_IDX_W); r++)
            write_reg(r, DUR_W'($urandom_range(16'hFFFF)));
        codes_waiting.push_back(8'h5A);
        wait_drained();

        // Random phases: new timing each phase, sender pauses between them.
        for (int p = 0; p < RAND_PHASES; p++) begin
            load_timing(pick_duration(), pick_duration(), pick_duration(),
                        pick_duration(), pick_duration());
            repeat (RAND_CODES) codes_waiting.push_back(8'($urandom_range(255)));
            wait_drained();
        end

        wait_drained();
        $display("Sent %0d codes under %0d timing settings, checked %0d segments",
                 codes_sent, settings, seg_total);
        $display("Long output stall %s, %0d mismatches", hold_done ? "done" : "missed",
                 mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
